@@ rtl/bdls_pkg.sv @@
`default_nettype none
package bdls_pkg;

    localparam int MAX_SRC_DIM   = 4096;
    localparam int MAX_DST_WIDTH = 1024;
    localparam int SHADE_LEVELS  = 8;

    localparam int DIM_W   = 13;
    localparam int SUM_W   = 32;
    localparam int AREA_W  = 2 * DIM_W - 1;
    localparam int QUOT_W  = 9;
    localparam int LUMA_W  = 18;

    localparam logic [2:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_INVERT     = 3'd4;

    localparam logic [9:0]  LUMA_R = 10'd299;
    localparam logic [9:0]  LUMA_G = 10'd587;
    localparam logic [9:0]  LUMA_B = 10'd114;
    localparam int          SHADE_STEP = 1000 * (256 / SHADE_LEVELS);
    localparam logic [2:0]  SHADE_MAX  = 3'(SHADE_LEVELS - 1);

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SETUP,
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_MEAN,
        ST_LUMA,
        ST_EMIT
    } bdls_state_t;

    typedef struct packed {
        logic [DIM_W-1:0] q;
        logic [DIM_W-1:0] r;
    } edge_t;

    typedef struct packed {
        logic             start;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
    } mean_req_t;

endpackage
`default_nettype wire

@@ rtl/bdls_mean_div.sv @@
`default_nettype none
module bdls_mean_div
    import bdls_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mean_req_t        req,
    input  wire logic [SUM_W-1:0] sum_red,
    input  wire logic [SUM_W-1:0] sum_green,
    input  wire logic [SUM_W-1:0] sum_blue,
    output logic                  done,
    output logic [7:0]            avg_red,
    output logic [7:0]            avg_green,
    output logic [7:0]            avg_blue
);

    localparam int REM_W = SUM_W + 2;
    localparam logic [3:0] CNT_AREA = 4'(QUOT_W + 2);
    localparam logic [3:0] CNT_INIT = 4'(QUOT_W + 1);

    logic [3:0]        cnt_reg;
    logic              done_reg;
    logic [DIM_W-1:0]  w_reg, h_reg;
    logic [AREA_W-1:0] area_reg;
    logic [SUM_W-1:0]  sum_reg [3];
    logic [REM_W-1:0]  rem_reg [3];
    logic [REM_W-1:0]  dsh_reg;
    logic [QUOT_W-1:0] quo_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (cnt_reg == 4'd1);
            if (req.start)
                cnt_reg <= CNT_AREA;
            else if (cnt_reg != 4'd0)
                cnt_reg <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            w_reg      <= req.width;
            h_reg      <= req.height;
            sum_reg[0] <= sum_red;
            sum_reg[1] <= sum_green;
            sum_reg[2] <= sum_blue;
        end
        else if (cnt_reg == CNT_AREA)
        begin
            area_reg <= AREA_W'(w_reg) * AREA_W'(h_reg);
        end
        else if (cnt_reg == CNT_INIT)
        begin
            // numerator 2*sum + area, divisor 2*area aligned to the top quotient bit
            dsh_reg <= REM_W'({area_reg, 1'b0}) << (QUOT_W - 1);
            for (int i = 0; i < 3; i++)
            begin
                rem_reg[i] <= REM_W'({sum_reg[i], 1'b0}) + REM_W'(area_reg);
                quo_reg[i] <= '0;
            end
        end
        else if (cnt_reg != 4'd0)
        begin
            dsh_reg <= dsh_reg >> 1;
            for (int i = 0; i < 3; i++)
            begin
                if (rem_reg[i] >= dsh_reg)
                begin
                    rem_reg[i] <= rem_reg[i] - dsh_reg;
                    quo_reg[i] <= {quo_reg[i][QUOT_W-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[i] <= {quo_reg[i][QUOT_W-2:0], 1'b0};
                end
            end
        end
    end

    assign done      = done_reg;
    assign avg_red   = quo_reg[0][QUOT_W-1] ? 8'hFF : quo_reg[0][7:0];
    assign avg_green = quo_reg[1][QUOT_W-1] ? 8'hFF : quo_reg[1][7:0];
    assign avg_blue  = quo_reg[2][QUOT_W-1] ? 8'hFF : quo_reg[2][7:0];

endmodule
`default_nettype wire

@@ rtl/box_downscale_luma_shade.sv @@
`default_nettype none
// Area-averaging RGB downscaler with a 3-bit luma shade per output block. Feed
// source pixels in raster order on s_*, flagging the top-left pixel with
// s_tuser; each block boundary is round(i*src/dst) with halves rounded up.
// One result leaves on m_* with the last pixel of every block: block column
// and row, the rounded channel means and floor(luma/32000) (inverted when
// invert_shades is set); m_tlast marks the final block of the frame. Running
// per-column sums live in a 1024 x 96 single-port memory that is read, updated
// and written back once per pixel, so a plain pixel passes through accept,
// memory read and write back. A pixel that closes a block also passes through
// an area multiply and a 9-step restoring divide for the three means, a luma
// stage and the hand-off into the output register. After reset and after any
// write to a defined register, the block runs a setup that divides source by
// destination size on each axis with a bit-serial divider; s_tready stays low
// meanwhile. Block edges then advance by add and one compare.
// Sizes out of range are clamped: zero acts as one, the destination never
// exceeds the source. Write registers only while no transaction is in flight.
module box_downscale_luma_shade
    import bdls_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [12:0] cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // pixel_red, pixel_green, pixel_blue
    input  wire logic        s_tuser,   // first_of_frame
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0] m_tdata,  // out_column, out_row, avg_red/green/blue, shade_index, pad
    output logic             m_tlast    // last_of_frame
);

    // Configuration
    logic [12:0] src_width_reg, src_height_reg, dst_height_reg;
    logic [10:0] dst_width_reg;
    logic        invert_reg;

    logic [DIM_W-1:0] sw, sh, dh, dw13, dst_w_clamp, dst_h_clamp;
    logic [10:0]      dw;

    always_comb
    begin
        sw = (src_width_reg == '0) ? 13'd1 :
             (src_width_reg > 13'(MAX_SRC_DIM)) ? 13'(MAX_SRC_DIM) : src_width_reg;
        sh = (src_height_reg == '0) ? 13'd1 :
             (src_height_reg > 13'(MAX_SRC_DIM)) ? 13'(MAX_SRC_DIM) : src_height_reg;
        dst_w_clamp = (dst_width_reg == '0) ? 13'd1 :
                      (dst_width_reg > 11'(MAX_DST_WIDTH)) ? 13'(MAX_DST_WIDTH) :
                      {2'b00, dst_width_reg};
        dst_h_clamp = (dst_height_reg == '0) ? 13'd1 :
                      (dst_height_reg > 13'(MAX_SRC_DIM)) ? 13'(MAX_SRC_DIM) : dst_height_reg;
        dw13 = (dst_w_clamp > sw) ? sw : dst_w_clamp;
        dw   = dw13[10:0];
        dh   = (dst_h_clamp > sh) ? sh : dst_h_clamp;
    end

    // Control
    bdls_state_t state_reg, state_next;
    logic        accept, mem_we, out_free, out_load, emit, cfg_hit;
    mean_req_t   mean_req;
    logic        mean_done;

    // Setup divider
    logic              axis_reg;
    logic [3:0]        div_cnt_reg;
    logic [DIM_W-1:0]  div_num_reg, div_quo_reg;
    logic [11:0]       div_rem_reg;
    logic [DIM_W-1:0]  div_d, div_trial, div_quo_next;
    logic [11:0]       div_rem_next;
    logic              div_ge;

    logic [DIM_W-1:0] col_step_q_reg, row_step_q_reg;
    logic [11:0]      col_step_rem_reg, row_step_rem_reg;

    // Position state
    logic [11:0]      sx_reg, sy_reg, rb_reg;
    logic [9:0]       cb_reg;
    logic [DIM_W-1:0] cs_reg, ce_reg, rs_reg, re_reg, col_rem_reg, row_rem_reg;

    // Pixel and result holding
    logic [7:0]       pix_reg [3];
    logic [9:0]       res_col_reg;
    logic [11:0]      res_row_reg;
    logic             res_last_reg;
    logic [7:0]       avg_reg [3];
    logic [LUMA_W-1:0] luma_reg;
    logic             out_valid_reg, out_last_reg;
    logic [55:0]      out_data_reg;

    // Sum memory: red, green, blue sums from the low bits up
    logic [3*SUM_W-1:0] sum_mem [MAX_DST_WIDTH];
    logic [3*SUM_W-1:0] mem_rdata_reg, mem_wdata;

    function automatic edge_t edge_fix(logic [DIM_W-1:0] q, logic [14:0] r,
                                       logic [DIM_W-1:0] d);
        edge_t       e;
        logic [14:0] d2;
        d2 = {1'b0, d, 1'b0};
        if (r >= d2)
        begin
            e.q = q + 13'd1;
            e.r = DIM_W'(r - d2);
        end
        else
        begin
            e.q = q;
            e.r = DIM_W'(r);
        end
        return e;
    endfunction

    function automatic logic [2:0] shade_of(logic [LUMA_W-1:0] l);
        logic [2:0] s;
        s = '0;
        for (int k = 1; k < SHADE_LEVELS; k++)
        begin
            if (l >= LUMA_W'(k * SHADE_STEP))
                s = 3'(k);
        end
        return s;
    endfunction

    edge_t col_init, row_init, col_adv, row_adv;

    always_comb
    begin
        col_init = edge_fix(col_step_q_reg,
                            {2'b00, col_step_rem_reg, 1'b0} + {2'b00, dw13}, dw13);
        row_init = edge_fix(row_step_q_reg,
                            {2'b00, row_step_rem_reg, 1'b0} + {2'b00, dh}, dh);
        col_adv  = edge_fix(ce_reg + col_step_q_reg,
                            {2'b00, col_rem_reg} + {2'b00, col_step_rem_reg, 1'b0}, dw13);
        row_adv  = edge_fix(re_reg + row_step_q_reg,
                            {2'b00, row_rem_reg} + {2'b00, row_step_rem_reg, 1'b0}, dh);
    end

    // One restoring step of the setup divide
    always_comb
    begin
        div_d        = axis_reg ? dh : dw13;
        div_trial    = {div_rem_reg, div_num_reg[DIM_W-1]};
        div_ge       = (div_trial >= div_d);
        div_rem_next = div_ge ? 12'(div_trial - div_d) : div_trial[11:0];
        div_quo_next = {div_quo_reg[DIM_W-2:0], div_ge};
    end

    // Pixel update decisions
    logic [DIM_W-1:0] sx_inc, sy_inc;
    logic [10:0]      cb_inc;
    logic [DIM_W-1:0] rb_inc;
    logic             col_done, row_done, col_wrap, row_wrap, first_px, degenerate;
    logic [SUM_W-1:0] sum_new [3];

    always_comb
    begin
        sx_inc     = {1'b0, sx_reg} + 13'd1;
        sy_inc     = {1'b0, sy_reg} + 13'd1;
        cb_inc     = {1'b0, cb_reg} + 11'd1;
        rb_inc     = {1'b0, rb_reg} + 13'd1;
        col_done   = (sx_inc >= ce_reg);
        row_done   = (sy_inc >= re_reg);
        col_wrap   = (sx_inc >= sw) || (cb_inc >= dw);
        row_wrap   = (sy_inc >= sh) || (rb_inc >= dh);
        emit       = col_done && row_done;
        first_px   = ({1'b0, sx_reg} == cs_reg) && ({1'b0, sy_reg} == rs_reg);
        degenerate = (ce_reg <= cs_reg) || (re_reg <= rs_reg);
        for (int i = 0; i < 3; i++)
        begin
            sum_new[i] = first_px ? {24'd0, pix_reg[i]}
                                  : mem_rdata_reg[i*SUM_W +: SUM_W] + {24'd0, pix_reg[i]};
        end
        mem_wdata = {sum_new[2], sum_new[1], sum_new[0]};
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:   state_next = ST_SETUP;
            ST_SETUP:  if (div_cnt_reg == 4'd0 && axis_reg) state_next = ST_INIT;
            ST_INIT:   state_next = ST_IDLE;
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = ST_UPDATE;
            ST_UPDATE: state_next = emit ? ST_MEAN : ST_IDLE;
            ST_MEAN:   if (mean_done) state_next = ST_LUMA;
            ST_LUMA:   state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_LOAD;
        endcase
        if (cfg_hit)
            state_next = ST_LOAD;
    end

    // Control outputs
    always_comb
    begin
        cfg_hit        = cfg_we && (cfg_addr <= CFG_INVERT);
        out_free       = !out_valid_reg || m_tready;
        s_tready       = (state_reg == ST_IDLE);
        accept         = s_tvalid && s_tready;
        mem_we         = (state_reg == ST_UPDATE);
        mean_req.start = (state_reg == ST_UPDATE) && emit;
        mean_req.width  = degenerate ? 13'd1 : ce_reg - cs_reg;
        mean_req.height = degenerate ? 13'd1 : re_reg - rs_reg;
        out_load       = (state_reg == ST_EMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= 13'd640;
            src_height_reg <= 13'd480;
            dst_width_reg  <= 11'd80;
            dst_height_reg <= 13'd60;
            invert_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data;
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data;
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[10:0];
                CFG_DST_HEIGHT: dst_height_reg <= cfg_data;
                CFG_INVERT:     invert_reg     <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    // Setup divider and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg         <= 1'b0;
            div_cnt_reg      <= '0;
            div_num_reg      <= '0;
            div_rem_reg      <= '0;
            div_quo_reg      <= '0;
            col_step_q_reg   <= '0;
            col_step_rem_reg <= '0;
            row_step_q_reg   <= '0;
            row_step_rem_reg <= '0;
            sx_reg           <= '0;
            sy_reg           <= '0;
            cb_reg           <= '0;
            rb_reg           <= '0;
            cs_reg           <= '0;
            ce_reg           <= '0;
            rs_reg           <= '0;
            re_reg           <= '0;
            col_rem_reg      <= '0;
            row_rem_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                ST_LOAD:
                begin
                    axis_reg    <= 1'b0;
                    div_cnt_reg <= 4'(DIM_W - 1);
                    div_num_reg <= sw;
                    div_rem_reg <= '0;
                    div_quo_reg <= '0;
                end
                ST_SETUP:
                begin
                    div_num_reg <= div_num_reg << 1;
                    div_rem_reg <= div_rem_next;
                    div_quo_reg <= div_quo_next;
                    div_cnt_reg <= div_cnt_reg - 4'd1;
                    if (div_cnt_reg == 4'd0)
                    begin
                        if (!axis_reg)
                        begin
                            col_step_q_reg   <= div_quo_next;
                            col_step_rem_reg <= div_rem_next;
                            axis_reg         <= 1'b1;
                            div_cnt_reg      <= 4'(DIM_W - 1);
                            div_num_reg      <= sh;
                            div_rem_reg      <= '0;
                            div_quo_reg      <= '0;
                        end
                        else
                        begin
                            row_step_q_reg   <= div_quo_next;
                            row_step_rem_reg <= div_rem_next;
                        end
                    end
                end
                ST_INIT:
                begin
                    sx_reg      <= '0;
                    cb_reg      <= '0;
                    cs_reg      <= '0;
                    ce_reg      <= col_init.q;
                    col_rem_reg <= col_init.r;
                    sy_reg      <= '0;
                    rb_reg      <= '0;
                    rs_reg      <= '0;
                    re_reg      <= row_init.q;
                    row_rem_reg <= row_init.r;
                end
                ST_IDLE:
                begin
                    // first_of_frame restarts the frame before the pixel is summed
                    if (accept && s_tuser)
                    begin
                        sx_reg      <= '0;
                        cb_reg      <= '0;
                        cs_reg      <= '0;
                        ce_reg      <= col_init.q;
                        col_rem_reg <= col_init.r;
                        sy_reg      <= '0;
                        rb_reg      <= '0;
                        rs_reg      <= '0;
                        re_reg      <= row_init.q;
                        row_rem_reg <= row_init.r;
                    end
                end
                ST_UPDATE:
                begin
                    if (!col_done)
                    begin
                        sx_reg <= sx_inc[11:0];
                    end
                    else if (!col_wrap)
                    begin
                        cb_reg      <= cb_inc[9:0];
                        cs_reg      <= ce_reg;
                        ce_reg      <= col_adv.q;
                        col_rem_reg <= col_adv.r;
                        sx_reg      <= sx_inc[11:0];
                    end
                    else
                    begin
                        sx_reg      <= '0;
                        cb_reg      <= '0;
                        cs_reg      <= '0;
                        ce_reg      <= col_init.q;
                        col_rem_reg <= col_init.r;
                        if (!row_done)
                        begin
                            sy_reg <= sy_inc[11:0];
                        end
                        else if (!row_wrap)
                        begin
                            rb_reg      <= rb_inc[11:0];
                            rs_reg      <= re_reg;
                            re_reg      <= row_adv.q;
                            row_rem_reg <= row_adv.r;
                            sy_reg      <= sy_inc[11:0];
                        end
                        else
                        begin
                            sy_reg      <= '0;
                            rb_reg      <= '0;
                            rs_reg      <= '0;
                            re_reg      <= row_init.q;
                            row_rem_reg <= row_init.r;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Sum memory: read-modify-write one column entry per pixel
    always_ff @(posedge clk)
    begin
        if (mem_we)
            sum_mem[cb_reg] <= mem_wdata;
        mem_rdata_reg <= sum_mem[cb_reg];
    end

    // Mean divider
    logic [7:0] mean_avg [3];

    bdls_mean_div u_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mean_req),
        .sum_red   (sum_new[0]),
        .sum_green (sum_new[1]),
        .sum_blue  (sum_new[2]),
        .done      (mean_done),
        .avg_red   (mean_avg[0]),
        .avg_green (mean_avg[1]),
        .avg_blue  (mean_avg[2])
    );

    // Payload holding registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg[0] <= s_tdata[7:0];
            pix_reg[1] <= s_tdata[15:8];
            pix_reg[2] <= s_tdata[23:16];
        end
        if (mean_req.start)
        begin
            res_col_reg  <= cb_reg;
            res_row_reg  <= rb_reg;
            res_last_reg <= (cb_inc == dw) && (rb_inc == dh);
        end
        if (state_reg == ST_MEAN && mean_done)
        begin
            avg_reg <= mean_avg;
        end
        if (state_reg == ST_LUMA)
        begin
            luma_reg <= LUMA_W'(LUMA_R) * LUMA_W'(avg_reg[0])
                      + LUMA_W'(LUMA_G) * LUMA_W'(avg_reg[1])
                      + LUMA_W'(LUMA_B) * LUMA_W'(avg_reg[2]);
        end
    end

    // Output register: hold until the transaction completes
    logic [2:0] shade;

    always_comb
    begin
        shade = invert_reg ? SHADE_MAX - shade_of(luma_reg) : shade_of(luma_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {7'd0, shade, avg_reg[2], avg_reg[1], avg_reg[0],
                             res_row_reg, res_col_reg};
            out_last_reg <= res_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire
